[hdl/rowerr_pkg.sv]
package rowerr_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int FRAC_BITS = 16;
   localparam int OUT_BITS = 32;
   localparam int SUM_BITS = 64;
   localparam int ITER_COUNT = 32;
   localparam int CNT_W = $clog2(ITER_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DIVIDE,
      ST_UPDATE,
      ST_ROOT,
      ST_EMIT
   } rowerr_state_type;

   typedef struct packed {
      logic load;
      logic square;
      logic div_step;
      logic accum;
      logic update;
      logic root_step;
      logic emit;
   } rowerr_cmd_type;

   typedef struct packed {
      logic row_end;
   } rowerr_status_type;

endpackage

[hdl/rowerr_ctrl.sv]
module rowerr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  rowerr_pkg::rowerr_status_type status,
   output rowerr_pkg::rowerr_cmd_type    cmd
);
   import rowerr_pkg::*;

   rowerr_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             cnt_last;
   logic             out_free;

   assign cnt_last = (cnt_ff == CNT_W'(ITER_COUNT - 1));
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_DIVIDE;
         ST_DIVIDE: if (cnt_last) state_in = ST_UPDATE;
         ST_UPDATE: state_in = status.row_end ? ST_ROOT : ST_IDLE;
         ST_ROOT:   if (cnt_last) state_in = ST_EMIT;
         ST_EMIT:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_SQUARE: cmd.square = 1'b1;
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            // product is ready on the first divide cycle
            cmd.accum = (cnt_ff == '0);
         end
         ST_UPDATE: cmd.update = 1'b1;
         ST_ROOT:   cmd.root_step = 1'b1;
         ST_EMIT:   cmd.emit = out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      if ((state_ff == ST_DIVIDE || state_ff == ST_ROOT) && !cnt_last) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = '0;
      end
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted twice in a row");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a pending beat");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("emitted result not presented");

   a_accum_once: assert property (@(posedge clock) disable iff (reset)
      cmd.accum |=> !cmd.accum)
      else $error("square accumulated twice");

endmodule

[hdl/rowerr_dp.sv]
module rowerr_dp #(
   parameter int VALUE_BITS = rowerr_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rowerr_pkg::rowerr_cmd_type    cmd,
   output rowerr_pkg::rowerr_status_type status,
   input  logic [31:0]                   req_candidate_value,
   input  logic [31:0]                   req_reference_value,
   input  logic                          req_row_end,
   output logic [31:0]                   rsp_l2_error,
   output logic [31:0]                   rsp_max_rel_error,
   output logic                          rsp_sum_saturated
);
   import rowerr_pkg::*;

   localparam int VB = VALUE_BITS;
   localparam int ROOT_REM_W = OUT_BITS + 1;

   // operands of the current element
   logic [VB-1:0] ad_ff, ad_in;
   logic [VB-1:0] ar_ff, ar_in;
   logic          row_end_ff, row_end_in;

   logic signed [VB:0] cand_ext, ref_ext, diff;

   // square and accumulators
   logic [2*VB-1:0]     prod;
   logic [SUM_BITS-1:0] sq_ff, sq_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic [SUM_BITS:0]   sum_wide;
   logic                ovf_ff, ovf_in;
   logic [OUT_BITS-1:0] max_ff, max_in;

   // divider
   logic [VB-1:0]       rem_ff, rem_in;
   logic [OUT_BITS-1:0] nq_ff, nq_in;
   logic                zero_ff, zero_in;
   logic                qsat_ff, qsat_in;
   logic [VB:0]         rem_sh, rem_sub;
   logic                div_ge;
   logic [OUT_BITS-1:0] rel;

   // square root
   logic [ROOT_REM_W-1:0] rr_ff, rr_in;
   logic [OUT_BITS-1:0]   root_ff, root_in;
   logic [SUM_BITS-1:0]   rx_ff, rx_in;
   logic [ROOT_REM_W+1:0] rr_sh, rr_trial, rr_sub;
   logic                  root_ge;

   // result register
   logic [OUT_BITS-1:0] l2_ff, l2_in;
   logic [OUT_BITS-1:0] mre_ff, mre_in;
   logic                sat_ff, sat_in;

   always_comb begin
      cand_ext = {req_candidate_value[VB-1], req_candidate_value[VB-1:0]};
      ref_ext  = {req_reference_value[VB-1], req_reference_value[VB-1:0]};
      diff     = cand_ext - ref_ext;
   end

   always_comb begin
      ad_in = ad_ff;
      ar_in = ar_ff;
      row_end_in = row_end_ff;
      if (cmd.load) begin
         ad_in = diff[VB] ? VB'(-diff) : diff[VB-1:0];
         ar_in = ref_ext[VB] ? VB'(-ref_ext) : ref_ext[VB-1:0];
         row_end_in = req_row_end;
      end
   end

   assign prod = ad_ff * ad_ff;
   assign sq_in = cmd.square ? SUM_BITS'(prod) : sq_ff;

   assign rem_sh  = {rem_ff, nq_ff[OUT_BITS-1]};
   assign div_ge  = (rem_sh >= {1'b0, ar_ff});
   assign rem_sub = rem_sh - {1'b0, ar_ff};

   always_comb begin
      rem_in  = rem_ff;
      nq_in   = nq_ff;
      zero_in = zero_ff;
      qsat_in = qsat_ff;
      if (cmd.square) begin
         zero_in = (ar_ff == '0);
         // quotient overflows 32 bits when |d| >= |ref| * 2^16
         qsat_in = ({{FRAC_BITS{1'b0}}, ad_ff} >= {ar_ff, {FRAC_BITS{1'b0}}});
         rem_in  = ad_ff >> FRAC_BITS;
         nq_in   = {ad_ff[FRAC_BITS-1:0], {(OUT_BITS - FRAC_BITS){1'b0}}};
      end else if (cmd.div_step) begin
         rem_in = div_ge ? rem_sub[VB-1:0] : rem_sh[VB-1:0];
         nq_in  = {nq_ff[OUT_BITS-2:0], div_ge};
      end
   end

   always_comb begin
      if (zero_ff) begin
         rel = '0;
      end else if (qsat_ff) begin
         rel = '1;
      end else begin
         rel = nq_ff;
      end
   end

   assign sum_wide = {1'b0, sum_ff} + {1'b0, sq_ff};

   always_comb begin
      sum_in = sum_ff;
      ovf_in = ovf_ff;
      max_in = max_ff;
      if (cmd.emit) begin
         sum_in = '0;
         ovf_in = 1'b0;
         max_in = '0;
      end else begin
         if (cmd.accum) begin
            if (sum_wide[SUM_BITS]) begin
               sum_in = '1;
               ovf_in = 1'b1;
            end else begin
               sum_in = sum_wide[SUM_BITS-1:0];
            end
         end
         if (cmd.update && (rel > max_ff)) begin
            max_in = rel;
         end
      end
   end

   // two radicand bits per step, one root bit out
   assign rr_sh    = {rr_ff, rx_ff[SUM_BITS-1 -: 2]};
   assign rr_trial = {1'b0, root_ff, 2'b01};
   assign root_ge  = (rr_sh >= rr_trial);
   assign rr_sub   = rr_sh - rr_trial;

   always_comb begin
      rr_in   = rr_ff;
      root_in = root_ff;
      rx_in   = rx_ff;
      if (cmd.update) begin
         rr_in   = '0;
         root_in = '0;
         rx_in   = sum_ff;
      end else if (cmd.root_step) begin
         rr_in   = root_ge ? rr_sub[ROOT_REM_W-1:0] : rr_sh[ROOT_REM_W-1:0];
         root_in = {root_ff[OUT_BITS-2:0], root_ge};
         rx_in   = {rx_ff[SUM_BITS-3:0], 2'b00};
      end
   end

   always_comb begin
      l2_in  = l2_ff;
      mre_in = mre_ff;
      sat_in = sat_ff;
      if (cmd.emit) begin
         l2_in  = root_ff;
         mre_in = max_ff;
         sat_in = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         ovf_ff <= 1'b0;
         max_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         ovf_ff <= ovf_in;
         max_ff <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      ad_ff      <= ad_in;
      ar_ff      <= ar_in;
      row_end_ff <= row_end_in;
      sq_ff      <= sq_in;
      rem_ff     <= rem_in;
      nq_ff      <= nq_in;
      zero_ff    <= zero_in;
      qsat_ff    <= qsat_in;
      rr_ff      <= rr_in;
      root_ff    <= root_in;
      rx_ff      <= rx_in;
      l2_ff      <= l2_in;
      mre_ff     <= mre_in;
      sat_ff     <= sat_in;
   end

   assign status.row_end    = row_end_ff;
   assign rsp_l2_error      = l2_ff;
   assign rsp_max_rel_error = mre_ff;
   assign rsp_sum_saturated = sat_ff;

endmodule

[hdl/row_error_norm_unit.sv]
// each element passes a square, radix-2 divide steps (one quotient bit each) and a max update
// a row-end element adds square-root steps, then loads the result register once the output is free
// elements go one at a time through the shared serial divider; a new one is accepted only in idle
// the result register lets the next element in while a result beat waits
// reset: synchronous active high, clears the controller, the accumulators and rsp_valid
module row_error_norm_unit #(
   parameter int VALUE_BITS = rowerr_pkg::VALUE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_candidate_value,
   input  logic [31:0] req_reference_value,
   input  logic        req_row_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_l2_error,
   output logic [31:0] rsp_max_rel_error,
   output logic        rsp_sum_saturated
);
   import rowerr_pkg::*;

   rowerr_cmd_type    cmd;
   rowerr_status_type status;

   rowerr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rowerr_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_candidate_value (req_candidate_value),
      .req_reference_value (req_reference_value),
      .req_row_end         (req_row_end),
      .rsp_l2_error        (rsp_l2_error),
      .rsp_max_rel_error   (rsp_max_rel_error),
      .rsp_sum_saturated   (rsp_sum_saturated)
   );

endmodule

[tb/sv/row_error_norm_unit_test.sv]
`timescale 1ns / 100ps

module row_error_norm_unit_test;

   import rowerr_pkg::*;

   localparam int VALUE_BITS = VALUE_BITS_DEFAULT;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 100;
   localparam int PHASE_ITEMS = 362;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_candidate_value;
   logic [31:0] req_reference_value;
   logic        req_row_end;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_l2_error;
   logic [31:0] rsp_max_rel_error;
   logic        rsp_sum_saturated;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int elements_sent = 0;
   int quiet_cycles = 0;

   typedef struct {
      logic [31:0] l2_error;
      logic [31:0] max_rel_error;
      logic        sum_saturated;
   } row_norms_type;

   class error_norm_scoreboard;
      logic [63:0]   square_sum;
      logic [31:0]   max_relative;
      logic          overflow_seen;
      row_norms_type expected_norms[$];
      int            error_count;
      int            rows_checked;
      int            saturated_rows;
      int            zero_refs;
      int            capped_ratios;

      function new();
         square_sum = '0;
         max_relative = '0;
         overflow_seen = 1'b0;
         error_count = 0;
         rows_checked = 0;
         saturated_rows = 0;
         zero_refs = 0;
         capped_ratios = 0;
      endfunction

      // keep VALUE_BITS low bits, sign extend to 34 bits
      function logic signed [33:0] widen(logic [31:0] raw);
         logic signed [31:0] t;
         logic signed [33:0] w;
         t = raw << (32 - VALUE_BITS);
         w = t;
         return w >>> (32 - VALUE_BITS);
      endfunction

      function logic [31:0] int_root(logic [63:0] x);
         logic [63:0] rem;
         logic [63:0] root;
         logic [63:0] probe;
         rem = x;
         root = '0;
         probe = 64'h1 << 62;
         while (probe != 0) begin
            if (rem >= root + probe) begin
               rem = rem - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root = root >> 1;
            end
            probe = probe >> 2;
         end
         return root[31:0];
      endfunction

      function void note_element(logic [31:0] cand_raw, logic [31:0] ref_raw, logic row_end);
         logic signed [33:0] cand;
         logic signed [33:0] refv;
         logic signed [33:0] diff;
         logic [32:0]        mag_diff;
         logic [32:0]        mag_ref;
         logic [63:0]        sq;
         logic [64:0]        total;
         logic [48:0]        quot;
         logic [31:0]        rel;
         row_norms_type      norms;
         cand = widen(cand_raw);
         refv = widen(ref_raw);
         diff = cand - refv;
         mag_diff = (diff < 0) ? 33'(-diff) : 33'(diff);
         mag_ref = (refv < 0) ? 33'(-refv) : 33'(refv);
         sq = 64'(mag_diff) * 64'(mag_diff);
         total = {1'b0, square_sum} + {1'b0, sq};
         if (total[64]) begin
            square_sum = '1;
            overflow_seen = 1'b1;
         end else begin
            square_sum = total[63:0];
         end
         rel = '0;
         if (mag_ref == 0) begin
            zero_refs++;
         end else begin
            quot = {mag_diff, 16'h0000} / 49'(mag_ref);
            if (quot > 49'hFFFF_FFFF) begin
               rel = '1;
               capped_ratios++;
            end else begin
               rel = quot[31:0];
            end
         end
         if (rel > max_relative) max_relative = rel;
         if (row_end) begin
            norms.l2_error = int_root(square_sum);
            norms.max_rel_error = max_relative;
            norms.sum_saturated = overflow_seen;
            expected_norms.push_back(norms);
            square_sum = '0;
            max_relative = '0;
            overflow_seen = 1'b0;
         end
      endfunction

      function void check_result(logic [31:0] l2, logic [31:0] rel, logic sat);
         row_norms_type want;
         if (expected_norms.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result beat: l2 %h rel %h sat %b", l2, rel, sat);
            return;
         end
         want = expected_norms.pop_front();
         rows_checked++;
         if (sat === 1'b1) saturated_rows++;
         if (l2 !== want.l2_error || rel !== want.max_rel_error
             || sat !== want.sum_saturated) begin
            error_count++;
            if (error_count <= 10)
               $display("row %0d: expected l2 %h rel %h sat %b, got l2 %h rel %h sat %b",
                        rows_checked, want.l2_error, want.max_rel_error, want.sum_saturated,
                        l2, rel, sat);
         end
      endfunction

      function int pending();
         return expected_norms.size();
      endfunction
   endclass

   error_norm_scoreboard norms_board;

   row_error_norm_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_candidate_value(req_candidate_value),
      .req_reference_value(req_reference_value),
      .req_row_end(req_row_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_l2_error(rsp_l2_error),
      .rsp_max_rel_error(rsp_max_rel_error),
      .rsp_sum_saturated(rsp_sum_saturated)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            norms_board.note_element(req_candidate_value, req_reference_value, req_row_end);
         if (rsp_valid && rsp_ready)
            norms_board.check_result(rsp_l2_error, rsp_max_rel_error, rsp_sum_saturated);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic send_element(input logic [31:0] cand, input logic [31:0] refv,
                               input logic row_end);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_candidate_value <= $urandom();
         req_reference_value <= $urandom();
         req_row_end <= 1'($urandom_range(0, 1));
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_candidate_value <= cand;
      req_reference_value <= refv;
      req_row_end <= row_end;
      do @(posedge clock); while (!req_ready);
      elements_sent++;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'($urandom_range(0, 511)) - 32'd256;
         4: return $urandom() >> $urandom_range(0, 31);
         5: return -($urandom() >> $urandom_range(0, 31));
         default: return $urandom();
      endcase
   endfunction

   // styles: 0 mixed, 1 candidate near reference, 2 opposite extremes, 3 zero or tiny reference
   task automatic send_row(input int len, input int style);
      logic [31:0] cand;
      logic [31:0] refv;
      for (int i = 0; i < len; i++) begin
         case (style)
            1: begin
               refv = pick_value();
               cand = refv + (32'($urandom_range(0, 2047)) - 32'd1024);
            end
            2: begin
               cand = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 65535)
                                           : 32'h8000_0000 + $urandom_range(0, 65535);
               refv = ~cand ^ $urandom_range(0, 255);
            end
            3: begin
               cand = $urandom();
               refv = ($urandom_range(0, 1) ? 32'h0 : 32'($urandom_range(1, 3)))
                      ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
            end
            default: begin
               cand = pick_value();
               refv = ($urandom_range(0, 9) == 0) ? 32'h0 : pick_value();
            end
         endcase
         send_element(cand, refv, i == len - 1);
      end
   endtask

   task automatic run_directed();
      send_element(32'h0000_0000, 32'h0000_0000, 1'b1);
      // two near full-scale squares saturate the sum
      send_element(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_element(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      // zero reference, squared difference still counts
      send_element(32'h0001_0000, 32'h0000_0000, 1'b1);
      send_element(32'h8000_0000, 32'h0000_0000, 1'b1);
      // quotients too big for Q16.16 twice, then ratios of zero and about one
      send_element(32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
      send_element(32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
      send_element(32'h0000_0001, 32'h0000_0001, 1'b1);
      send_element(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      // long row that keeps accumulating before its end
      send_element(32'h0003_0000, 32'h0001_0000, 1'b0);
      send_element(32'hFFFE_0000, 32'h0002_0000, 1'b0);
      send_element(32'h1234_5678, 32'h8000_0000, 1'b0);
      send_element(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      send_element(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      send_element(32'h0000_8000, 32'hFFFF_0000, 1'b1);
      send_element(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
      send_element(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
   endtask

   initial begin
      int phase_start;
      int len;
      int style;
      int pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_candidate_value = '0;
      req_reference_value = '0;
      req_row_end = 1'b0;
      norms_board = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 58; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 58; end
            default: begin send_idle_pct = 20; rsp_stall_pct = 20; end
         endcase
         phase_start = elements_sent;
         while (elements_sent - phase_start < PHASE_ITEMS) begin
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
            pick = $urandom_range(0, 99);
            style = (pick < 45) ? 0 : (pick < 75) ? 1 : (pick < 85) ? 2 : 3;
            send_row(len, style);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      while (norms_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d elements in %0d rows, %0d rows with a saturated sum",
               elements_sent, norms_board.rows_checked, norms_board.saturated_rows);
      $display("%0d zero-reference elements, %0d capped ratios, %0d mismatches",
               norms_board.zero_refs, norms_board.capped_ratios, norms_board.error_count);
      if (norms_board.error_count == 0 && norms_board.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[files.f]
hdl/rowerr_pkg.sv
hdl/rowerr_ctrl.sv
hdl/rowerr_dp.sv
hdl/row_error_norm_unit.sv
tb/sv/row_error_norm_unit_test.sv
